FILE: rtl/xcfp_pkg.sv
package xcfp_pkg;

  // register map
  localparam int unsigned RegAddrW = 4;
  localparam logic [1:0] REG_HEAD = 2'd0;
  localparam logic [1:0] REG_TAIL = 2'd1;
  localparam logic [1:0] REG_MAXLEN = 2'd2;

  localparam logic [7:0] HEAD_RST = 8'd126;
  localparam logic [7:0] TAIL_RST = 8'd127;
  localparam logic [15:0] MAXLEN_RST = 16'd1024;

  // parser phases
  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_CMD = 3'd1;
  localparam logic [2:0] PH_SER = 3'd2;
  localparam logic [2:0] PH_LEN1 = 3'd3;
  localparam logic [2:0] PH_LEN2 = 3'd4;
  localparam logic [2:0] PH_DATA = 3'd5;
  localparam logic [2:0] PH_CHECK = 3'd6;
  localparam logic [2:0] PH_TAIL = 3'd7;

  // status codes
  localparam logic [2:0] ST_CONT = 3'd0;
  localparam logic [2:0] ST_OK = 3'd1;
  localparam logic [2:0] ST_LONG = 3'd2;
  localparam logic [2:0] ST_XOR = 3'd3;
  localparam logic [2:0] ST_TAILBAD = 3'd4;

  localparam int unsigned TdataOutW = 40;
  localparam int unsigned TuserOutW = 4;

  typedef struct packed {
    logic [7:0]  head_byte;
    logic [7:0]  tail_byte;
    logic [15:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        payload_valid;
    logic [7:0]  command;
    logic [7:0]  serial;
    logic [15:0] payload_length;
    logic [7:0]  payload_byte;
  } res_t;

endpackage

FILE: rtl/xor_checked_frame_parser_core.sv
// Byte-stream frame parser with XOR check.
// Frame: head, command, serial, len_hi, len_lo, payload[len], check, tail.
// Slave stream: one received byte per beat (s_axis_tdata).
// Master stream: exactly one result beat per input beat, in order. tuser carries
// the status (continue, ok, too long, check mismatch, tail mismatch) and a
// payload-valid flag; tdata carries command, serial, declared length and the
// payload byte. Payload bytes are forwarded as they arrive; a later error
// status tells the consumer to drop them.
// Each result is registered in the output stage, or in the skid entry while the receiver stalls.
// Throughput: one byte per cycle while the skid entry is free; the per-byte
// work is a phase update and one XOR between input handshake and output register.
// The output register is backed by a one-entry skid stage, so the input keeps
// flowing while a result waits; if the receiver stalls, s_axis_tready drops
// once the skid entry fills and rises again as soon as it drains.
// Reset (rst_ni low, async) puts the parser in hunt mode with all frame
// fields zero, empties the output stages and loads register defaults
// (head 0x7E, tail 0x7F, max payload 1024). APB registers: 0x0 head,
// 0x4 tail, 0x8 max payload; write only while the stream is idle.
module xor_checked_frame_parser_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // APB config
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [xcfp_pkg::RegAddrW-1:0]     paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  // input bytes
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,   // [7:0] rx_byte
  // results
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [7:0] command, [15:8] serial, [31:16] payload_length, [39:32] payload_byte
  output logic [xcfp_pkg::TdataOutW-1:0]    m_axis_tdata,
  // [2:0] status, [3] payload_valid
  output logic [xcfp_pkg::TuserOutW-1:0]    m_axis_tuser
);

  xcfp_pkg::cfg_t cfg;
  xcfp_pkg::res_t step_res;
  xcfp_pkg::res_t out_res;
  logic           in_accept;

  assign in_accept = s_axis_tvalid & s_axis_tready;

  xcfp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // phase tracking and per-byte result
  xcfp_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .accept_i  (in_accept),
    .rx_byte_i (s_axis_tdata),
    .res_o     (step_res)
  );

  // result register + skid
  xcfp_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept),
    .res_i       (step_res),
    .ready_o     (s_axis_tready),
    .valid_o     (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .res_o       (out_res)
  );

  assign m_axis_tdata = {out_res.payload_byte, out_res.payload_length,
                         out_res.serial, out_res.command};
  assign m_axis_tuser = {out_res.payload_valid, out_res.status};

endmodule

FILE: rtl/xcfp_regs.sv
module xcfp_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [xcfp_pkg::RegAddrW-1:0]    paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output xcfp_pkg::cfg_t                   cfg_o
);

  xcfp_pkg::cfg_t cfg_q;
  logic           wr_en;
  logic [1:0]     idx;

  assign idx    = paddr[3:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.head_byte   <= xcfp_pkg::HEAD_RST;
      cfg_q.tail_byte   <= xcfp_pkg::TAIL_RST;
      cfg_q.max_payload <= xcfp_pkg::MAXLEN_RST;
    end else if (wr_en) begin
      case (idx)
        xcfp_pkg::REG_HEAD:   cfg_q.head_byte   <= pwdata[7:0];
        xcfp_pkg::REG_TAIL:   cfg_q.tail_byte   <= pwdata[7:0];
        xcfp_pkg::REG_MAXLEN: cfg_q.max_payload <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      xcfp_pkg::REG_HEAD:   prdata = {24'd0, cfg_q.head_byte};
      xcfp_pkg::REG_TAIL:   prdata = {24'd0, cfg_q.tail_byte};
      xcfp_pkg::REG_MAXLEN: prdata = {16'd0, cfg_q.max_payload};
      default:              prdata = 32'd0;
    endcase
  end

endmodule

FILE: rtl/xcfp_step.sv
module xcfp_step (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  xcfp_pkg::cfg_t cfg_i,
  input  logic           accept_i,
  input  logic [7:0]     rx_byte_i,
  output xcfp_pkg::res_t res_o
);

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  ser_q, ser_d;
  logic [15:0] len_q, len_d;
  logic [15:0] cnt_q, cnt_d;
  logic [7:0]  xor_q, xor_d;
  logic [2:0]  status;
  logic        pv;
  logic [15:0] cnt_inc;
  logic [15:0] len_full;

  assign cnt_inc  = cnt_q + 16'd1;
  assign len_full = {len_q[7:0], rx_byte_i};

  always_comb begin
    phase_d = phase_q;
    cmd_d   = cmd_q;
    ser_d   = ser_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    xor_d   = xor_q;
    status  = xcfp_pkg::ST_CONT;
    pv      = 1'b0;
    case (phase_q)
      xcfp_pkg::PH_HUNT: begin
        if (rx_byte_i == cfg_i.head_byte) phase_d = xcfp_pkg::PH_CMD;
      end
      xcfp_pkg::PH_CMD: begin
        cmd_d   = rx_byte_i;
        xor_d   = rx_byte_i;
        phase_d = xcfp_pkg::PH_SER;
      end
      xcfp_pkg::PH_SER: begin
        ser_d   = rx_byte_i;
        xor_d   = xor_q ^ rx_byte_i;
        phase_d = xcfp_pkg::PH_LEN1;
      end
      xcfp_pkg::PH_LEN1: begin
        len_d   = {8'd0, rx_byte_i};
        xor_d   = xor_q ^ rx_byte_i;
        phase_d = xcfp_pkg::PH_LEN2;
      end
      xcfp_pkg::PH_LEN2: begin
        len_d = len_full;
        xor_d = xor_q ^ rx_byte_i;
        cnt_d = 16'd0;
        if (len_full > cfg_i.max_payload) begin
          status  = xcfp_pkg::ST_LONG;
          phase_d = xcfp_pkg::PH_HUNT;
        end else if (len_full != 16'd0) begin
          phase_d = xcfp_pkg::PH_DATA;
        end else begin
          phase_d = xcfp_pkg::PH_CHECK;
        end
      end
      xcfp_pkg::PH_DATA: begin
        pv    = 1'b1;
        xor_d = xor_q ^ rx_byte_i;
        cnt_d = cnt_inc;
        if (cnt_inc >= len_q) phase_d = xcfp_pkg::PH_CHECK;
      end
      xcfp_pkg::PH_CHECK: begin
        if (xor_q == rx_byte_i) begin
          phase_d = xcfp_pkg::PH_TAIL;
        end else begin
          status  = xcfp_pkg::ST_XOR;
          phase_d = xcfp_pkg::PH_HUNT;
        end
      end
      default: begin
        status  = (rx_byte_i == cfg_i.tail_byte) ? xcfp_pkg::ST_OK : xcfp_pkg::ST_TAILBAD;
        phase_d = xcfp_pkg::PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= xcfp_pkg::PH_HUNT;
      cmd_q   <= 8'd0;
      ser_q   <= 8'd0;
      len_q   <= 16'd0;
      cnt_q   <= 16'd0;
      xor_q   <= 8'd0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      ser_q   <= ser_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      xor_q   <= xor_d;
    end
  end

  always_comb begin
    res_o.status         = status;
    res_o.payload_valid  = pv;
    res_o.command        = cmd_d;
    res_o.serial         = ser_d;
    res_o.payload_length = len_d;
    res_o.payload_byte   = pv ? rx_byte_i : 8'd0;
  end

  // payload beats never carry a frame verdict
  a_pv_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.payload_valid |-> res_o.status == xcfp_pkg::ST_CONT)
    else $error("payload beat with non-continue status");

  // tail byte always ends the frame
  a_tail_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && phase_q == xcfp_pkg::PH_TAIL) |=> phase_q == xcfp_pkg::PH_HUNT)
    else $error("parser did not return to hunt after tail");

  // payload counter never runs past the declared length
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == xcfp_pkg::PH_DATA) |-> cnt_q < len_q)
    else $error("payload count overran declared length");

  // hunting never yields a verdict
  a_hunt_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == xcfp_pkg::PH_HUNT) |-> res_o.status == xcfp_pkg::ST_CONT)
    else $error("status raised while hunting");

endmodule

FILE: rtl/xcfp_skid.sv
module xcfp_skid (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  xcfp_pkg::res_t res_i,
  output logic           ready_o,
  output logic           valid_o,
  input  logic           pop_ready_i,
  output xcfp_pkg::res_t res_o
);

  logic           out_valid_q;
  logic           skid_valid_q;
  xcfp_pkg::res_t out_q;
  xcfp_pkg::res_t skid_q;

  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign res_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop_ready_i) begin
      out_valid_q  <= skid_valid_q | push_i;
      skid_valid_q <= 1'b0;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop_ready_i) begin
      out_q <= skid_valid_q ? skid_q : res_i;
    end else if (push_i) begin
      skid_q <= res_i;
    end
  end

  a_skid_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held with empty output stage");

endmodule

FILE: test/xcfp_frame_check.sv
// Watches the register port and both streams of the frame parser, keeps its
// own copy of the parser state, and compares every result beat in order.
module xcfp_frame_check
  import xcfp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [RegAddrW-1:0]  paddr,
  input  logic [31:0]          pwdata,
  input  logic [31:0]          prdata,
  input  logic                 pready,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [TdataOutW-1:0] m_axis_tdata,
  input  logic [TuserOutW-1:0] m_axis_tuser,
  output int                   fail_cnt_o,
  output int                   pending_o,
  output int                   beats_o,
  output int                   frames_ok_o,
  output int                   frames_bad_o
);

  // register copies
  logic [7:0]  head_q;
  logic [7:0]  tail_q;
  logic [15:0] maxlen_q;

  // parser copy
  logic [2:0]  phase_q;
  logic [7:0]  cmd_q;
  logic [7:0]  serial_q;
  logic [15:0] len_q;
  logic [15:0] taken_q;
  logic [7:0]  xsum_q;

  res_t parse_results_q[$];
  res_t want_r;
  res_t got_r;

  int fail_cnt = 0;
  int beats = 0;
  int frames_ok = 0;
  int frames_bad = 0;
  int pending = 0;

  assign fail_cnt_o   = fail_cnt;
  assign pending_o    = pending;
  assign beats_o      = beats;
  assign frames_ok_o  = frames_ok;
  assign frames_bad_o = frames_bad;

  task automatic parse_byte(input logic [7:0] b, output res_t r);
    r = '0;
    r.status = ST_CONT;
    case (phase_q)
      PH_HUNT: begin
        if (b == head_q) phase_q = PH_CMD;
      end
      PH_CMD: begin
        cmd_q   = b;
        xsum_q  = b;
        phase_q = PH_SER;
      end
      PH_SER: begin
        serial_q = b;
        xsum_q   = xsum_q ^ b;
        phase_q  = PH_LEN1;
      end
      PH_LEN1: begin
        len_q   = {8'h00, b};
        xsum_q  = xsum_q ^ b;
        phase_q = PH_LEN2;
      end
      PH_LEN2: begin
        len_q   = {len_q[7:0], b};
        xsum_q  = xsum_q ^ b;
        taken_q = '0;
        if (len_q > maxlen_q) begin
          r.status = ST_LONG;
          phase_q  = PH_HUNT;
        end else if (len_q != 0) begin
          phase_q = PH_DATA;
        end else begin
          phase_q = PH_CHECK;
        end
      end
      PH_DATA: begin
        r.payload_valid = 1'b1;
        r.payload_byte  = b;
        xsum_q  = xsum_q ^ b;
        taken_q = taken_q + 16'd1;
        if (taken_q >= len_q) phase_q = PH_CHECK;
      end
      PH_CHECK: begin
        if (xsum_q == b) begin
          phase_q = PH_TAIL;
        end else begin
          r.status = ST_XOR;
          phase_q  = PH_HUNT;
        end
      end
      default: begin
        r.status = (b == tail_q) ? ST_OK : ST_TAILBAD;
        phase_q  = PH_HUNT;
      end
    endcase
    r.command        = cmd_q;
    r.serial         = serial_q;
    r.payload_length = len_q;
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   = HEAD_RST;
      tail_q   = TAIL_RST;
      maxlen_q = MAXLEN_RST;
      phase_q  = PH_HUNT;
      cmd_q    = '0;
      serial_q = '0;
      len_q    = '0;
      taken_q  = '0;
      xsum_q   = '0;
      parse_results_q.delete();
      pending  = 0;
    end else begin
      // result side first: a result never belongs to a byte taken on this edge
      if (m_axis_tvalid && m_axis_tready) begin
        got_r.command        = m_axis_tdata[7:0];
        got_r.serial         = m_axis_tdata[15:8];
        got_r.payload_length = m_axis_tdata[31:16];
        got_r.payload_byte   = m_axis_tdata[39:32];
        got_r.status         = m_axis_tuser[2:0];
        got_r.payload_valid  = m_axis_tuser[3];
        beats++;
        if (parse_results_q.size() == 0) begin
          $error("result beat with nothing expected (status %0d)", got_r.status);
          fail_cnt++;
        end else begin
          want_r = parse_results_q.pop_front();
          compare_field("status", want_r.status, got_r.status);
          compare_field("payload_valid", want_r.payload_valid, got_r.payload_valid);
          compare_field("command", want_r.command, got_r.command);
          compare_field("serial", want_r.serial, got_r.serial);
          compare_field("payload_length", want_r.payload_length, got_r.payload_length);
          compare_field("payload_byte", want_r.payload_byte, got_r.payload_byte);
          if (want_r.status == ST_OK) frames_ok++;
          else if (want_r.status != ST_CONT) frames_bad++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        parse_byte(s_axis_tdata, want_r);
        parse_results_q.push_back(want_r);
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[3:2])
            REG_HEAD:   head_q   = pwdata[7:0];
            REG_TAIL:   tail_q   = pwdata[7:0];
            REG_MAXLEN: maxlen_q = pwdata[15:0];
            default: ;
          endcase
        end else begin
          case (paddr[3:2])
            REG_HEAD:   compare_field("head_byte readback", head_q, prdata[7:0]);
            REG_TAIL:   compare_field("tail_byte readback", tail_q, prdata[7:0]);
            REG_MAXLEN: compare_field("max_payload readback", maxlen_q, prdata[15:0]);
            default: ;
          endcase
        end
      end
      pending = parse_results_q.size();
    end
  end

endmodule

FILE: test/tb_top.sv
// Stimulus and verdict for the frame parser. Checking lives in xcfp_frame_check.
module tb_top;
  import xcfp_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int BytesPerPhase = 130;
  localparam int NumPhases = 5;
  localparam int HoldCycles = 250;
  // unmapped register slot, writes must be ignored
  localparam logic [1:0] RegSpare = 2'd3;

  typedef enum int {FR_GOOD, FR_BADCHK, FR_BADTAIL, FR_LONG, FR_CUT} frame_kind_e;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [RegAddrW-1:0]  paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TdataOutW-1:0] m_axis_tdata;
  logic [TuserOutW-1:0] m_axis_tuser;

  int fail_cnt, pending, beats, frames_ok, frames_bad;

  // idle percentages, set per phase by the stimulus
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic long_hold_req = 1'b0;

  // what the stimulus believes the registers hold, for building frames
  logic [7:0]  cur_head = HEAD_RST;
  logic [7:0]  cur_tail = TAIL_RST;
  logic [15:0] cur_max = MAXLEN_RST;

  int bytes_sent = 0;
  int settings_cnt = 1;
  int cycles = 0;

  xor_checked_frame_parser_core u_top (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  xcfp_frame_check u_frame_check (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_cnt_o(fail_cnt), .pending_o(pending), .beats_o(beats),
    .frames_ok_o(frames_ok), .frames_bad_o(frames_bad)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request so the
  // output and skid stages fill and the parser has to push back.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
    end
  end

  // one byte beat, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b);
    if (send_idle_pct != 0) begin
      while ($urandom_range(99, 0) < send_idle_pct) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
  endtask

  // stream goes quiet and every result has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [7:0] h, input logic [7:0] t, input logic [15:0] m);
    apb_access(1'b1, REG_HEAD, {24'h0, h});
    apb_access(1'b1, REG_TAIL, {24'h0, t});
    apb_access(1'b1, REG_MAXLEN, {16'h0, m});
    apb_access(1'b0, REG_HEAD, '0);
    apb_access(1'b0, REG_TAIL, '0);
    apb_access(1'b0, REG_MAXLEN, '0);
    cur_head = h;
    cur_tail = t;
    cur_max  = m;
  endtask

  // Full or broken frame. Check covers command through the last payload byte.
  task automatic send_frame(input frame_kind_e kind, input logic [7:0] cmd,
                            input logic [7:0] ser, input logic [15:0] len);
    logic [7:0] xsum;
    logic [7:0] b;
    int cut_at;
    xsum = cmd ^ ser ^ len[15:8] ^ len[7:0];
    cut_at = $urandom_range(4, 1);
    send_byte(cur_head);
    send_byte(cmd);
    if (kind == FR_CUT && cut_at == 1) return;
    send_byte(ser);
    if (kind == FR_CUT && cut_at == 2) return;
    send_byte(len[15:8]);
    if (kind == FR_CUT && cut_at == 3) return;
    send_byte(len[7:0]);
    if (kind == FR_LONG || kind == FR_CUT) return;
    for (int i = 0; i < int'(len); i++) begin
      b = 8'($urandom_range(255, 0));
      xsum = xsum ^ b;
      send_byte(b);
    end
    send_byte(kind == FR_BADCHK ? xsum ^ 8'($urandom_range(255, 1)) : xsum);
    if (kind == FR_BADCHK) return;
    send_byte(kind == FR_BADTAIL ? cur_tail ^ 8'($urandom_range(255, 1)) : cur_tail);
  endtask

  // Random frame, mostly well formed, short payloads, sometimes right at the limit.
  task automatic random_frame();
    frame_kind_e kind;
    int pick, cap;
    logic [15:0] len;
    logic [7:0] b;
    pick = $urandom_range(99, 0);
    if (pick < 65) kind = FR_GOOD;
    else if (pick < 75) kind = FR_BADCHK;
    else if (pick < 83) kind = FR_BADTAIL;
    else if (pick < 90) kind = (cur_max != 16'hFFFF) ? FR_LONG : FR_GOOD;
    else kind = FR_CUT;
    cap = ($urandom_range(9, 0) == 0) ? 40 : 12;
    if (int'(cur_max) < cap) cap = int'(cur_max);
    len = 16'($urandom_range(cap, 0));
    if (int'(cur_max) <= 40 && $urandom_range(4, 0) == 0) len = cur_max;
    if (kind == FR_LONG) begin
      if ($urandom_range(1, 0) == 0) len = cur_max + 16'd1;
      else len = 16'($urandom_range(65535, int'(cur_max) + 1));
    end
    // line noise between frames, kept off the head value
    if ($urandom_range(99, 0) < 30) begin
      repeat ($urandom_range(3, 1)) begin
        b = 8'($urandom_range(255, 0));
        if (b == cur_head) b = ~b;
        send_byte(b);
      end
    end
    send_frame(kind, 8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)), len);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part on reset register values.
    send_byte(8'h00);                                // noise while hunting
    send_byte(8'hFF);
    send_frame(FR_GOOD, 8'hFF, 8'h00, 16'd0);        // zero length, straight to check
    send_frame(FR_LONG, 8'hA5, 8'h5A, 16'hFFFF);     // declared length over limit
    // head value as command and as payload, then a wrong check byte
    send_byte(cur_head);
    send_byte(cur_head);
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(cur_head);
    send_byte(8'h55);
    send_frame(FR_BADTAIL, 8'h3C, 8'hC3, 16'd0);     // tail mismatch
    drain();

    // spare slot write must leave everything alone
    apb_access(1'b1, RegSpare, 32'hFFFF_FFFF);

    for (int ph = 0; ph < NumPhases; ph++) begin
      int phase_start;
      drain();
      case (ph)
        0: set_regs(HEAD_RST, TAIL_RST, MAXLEN_RST);
        1: set_regs(8'h00, 8'hFF, 16'd0);
        2: set_regs(8'hFF, 8'h00, 16'hFFFF);
        3: set_regs(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                    16'($urandom_range(20, 1)));
        default: set_regs(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                          16'($urandom_range(255, 0)));
      endcase
      settings_cnt++;
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      // long receiver hold-off while the sender keeps offering
      if (ph == 0) long_hold_req <= 1'b1;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < BytesPerPhase) random_frame();
    end

    drain();
    repeat (4) @(posedge clk_i);

    $display("tb: %0d bytes over %0d register settings, %0d result beats checked",
             bytes_sent, settings_cnt, beats);
    $display("tb: %0d frames completed, %0d frames dropped on error", frames_ok, frames_bad);
    if (fail_cnt == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
